FILE: rtl/focus_break_interval_timer_unit_macros.svh
// Assertion macros for the timer RTL.
`ifndef FOCUS_BREAK_INTERVAL_TIMER_UNIT_MACROS_SVH
`define FOCUS_BREAK_INTERVAL_TIMER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define FBIT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define FBIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define FBIT_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define FBIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/fbit_pkg.sv
package fbit_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LEN_W       = 16;
	localparam int STAMP_W     = 32;
	localparam int SUB_W       = 10;
	localparam int TOTAL_W     = STAMP_W + 1;
	localparam int SECS_W      = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_DATA_W  = 32;

	localparam logic [LEN_W-1:0] FOCUS_RESET = LEN_W'(25 * 60);
	localparam logic [LEN_W-1:0] BREAK_RESET = LEN_W'(5 * 60);

	localparam logic [SUB_W-1:0] MS_PER_SECOND = SUB_W'(1000);

	// floor(x / 1000) = floor(floor(x / 8) / 125); reciprocal of 125 scaled by 2^37
	localparam int               RECIP_SHIFT = 37;
	localparam int               RECIP_W     = 31;
	localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(1099511628);

	localparam logic [TOTAL_W-1:0] COUNT_MAX =
		(TOTAL_W'(1) << COUNT_WIDTH) - TOTAL_W'(1);

	localparam logic [CFG_IDX_W-1:0] REG_FOCUS_LEN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_LEN = CFG_IDX_W'(1);

	localparam logic [2:0] KIND_TICK         = 3'd0;
	localparam logic [2:0] KIND_PREV_PAGE    = 3'd1;
	localparam logic [2:0] KIND_NEXT_PAGE    = 3'd2;
	localparam logic [2:0] KIND_CENTER_SHORT = 3'd3;
	localparam logic [2:0] KIND_CENTER_LONG  = 3'd4;
	localparam logic [2:0] KIND_CONSUME      = 3'd5;

	localparam logic [1:0] PAGE_OVERVIEW = 2'd0;
	localparam logic [1:0] PAGE_ACTIVITY = 2'd1;
	localparam logic [1:0] PAGE_FOCUS    = 2'd2;

	localparam logic PHASE_FOCUS = 1'b0;
	localparam logic PHASE_BREAK = 1'b1;

	localparam logic [3:0] FB_NONE      = 4'd0;
	localparam logic [3:0] FB_PAUSED    = 4'd4;
	localparam logic [3:0] FB_RESUMED   = 4'd5;
	localparam logic [3:0] FB_STARTED   = 4'd6;
	localparam logic [3:0] FB_VOICE_OFF = 4'd7;
	localparam logic [3:0] FB_RESET     = 4'd8;

	typedef enum logic [1:0] {
		RUN_READY  = 2'd0,
		RUN_ACTIVE = 2'd1,
		RUN_PAUSED = 2'd2
	} run_t;

	typedef struct packed {
		logic                  completed;
		logic                  voice_off;
		logic [3:0]            feedback;
		logic [15:0]           seconds_left;
		run_t                  run_state;
		logic                  phase;
		logic [1:0]            page;
	} fbit_res_t;

	function automatic logic [COUNT_WIDTH-1:0] reload(input logic [LEN_W-1:0] len);
		logic [TOTAL_W-1:0] v;
		v = TOTAL_W'(len);
		if (v > COUNT_MAX) begin
			return COUNT_MAX[COUNT_WIDTH-1:0];
		end
		return v[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [3:0] page_feedback(input logic [1:0] page);
		return 4'(page) + 4'd1;
	endfunction

endpackage

FILE: rtl/fbit_div1000.sv
module fbit_div1000
	import fbit_pkg::*;
(
	input  logic [TOTAL_W-1:0] total,
	output logic [SECS_W-1:0]  secs,
	output logic [SUB_W-1:0]   rem_ms
);

	logic [TOTAL_W-4:0]             eighths;
	logic [TOTAL_W-3+RECIP_W-1:0]   prod;
	logic [TOTAL_W:0]               whole_ms;
	logic [TOTAL_W-1:0]             diff;

	assign eighths  = total[TOTAL_W-1:3];
	assign prod     = (TOTAL_W-3+RECIP_W)'(eighths) * (TOTAL_W-3+RECIP_W)'(RECIP_125);
	assign secs     = SECS_W'(prod >> RECIP_SHIFT);

	// secs * 1000 = secs * 1024 - secs * 16 - secs * 8
	assign whole_ms = ((TOTAL_W+1)'(secs) << 10) - ((TOTAL_W+1)'(secs) << 4)
		- ((TOTAL_W+1)'(secs) << 3);
	assign diff     = total - whole_ms[TOTAL_W-1:0];
	assign rem_ms   = diff[SUB_W-1:0];

endmodule

FILE: rtl/fbit_core.sv
`include "focus_break_interval_timer_unit_macros.svh"

module fbit_core
	import fbit_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic [2:0]         kind,
	input  logic [STAMP_W-1:0] now_ms,
	input  logic [LEN_W-1:0]   focus_len,
	input  logic [LEN_W-1:0]   break_len,
	output fbit_res_t          res
);

	logic [1:0]             page_q, page_d;
	logic                   phase_q, phase_d;
	run_t                   run_q, run_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic [STAMP_W-1:0]     stamp_q, stamp_d;
	logic [SUB_W-1:0]       sub_q, sub_d;
	logic                   done_q, done_d;
	logic [3:0]             fb_q, fb_d;
	logic                   voice, comp;

	logic [STAMP_W-1:0]     elapsed;
	logic [TOTAL_W-1:0]     total;
	logic [SECS_W-1:0]      secs;
	logic [SUB_W-1:0]       rem_ms;

	logic                   adv_phase;
	run_t                   adv_run;
	logic [COUNT_WIDTH-1:0] adv_cnt;
	logic [SUB_W-1:0]       adv_sub;
	logic                   adv_done;

	assign elapsed = now_ms - stamp_q;
	assign total   = TOTAL_W'(elapsed) + TOTAL_W'(sub_q);

	fbit_div1000 u_div (
		.total  (total),
		.secs   (secs),
		.rem_ms (rem_ms)
	);

	// elapsed-time step of a running countdown
	always_comb begin
		adv_phase = phase_q;
		adv_run   = run_q;
		adv_cnt   = cnt_q;
		adv_sub   = rem_ms;
		adv_done  = done_q;
		if (secs != '0) begin
			if (TOTAL_W'(secs) < TOTAL_W'(cnt_q)) begin
				adv_cnt = cnt_q - COUNT_WIDTH'(secs);
			end else begin
				adv_phase = ~phase_q;
				adv_cnt   = reload(phase_q ? focus_len : break_len);
				adv_run   = RUN_READY;
				adv_sub   = '0;
				adv_done  = 1'b1;
			end
		end
	end

	always_comb begin
		page_d  = page_q;
		phase_d = phase_q;
		run_d   = run_q;
		cnt_d   = cnt_q;
		stamp_d = stamp_q;
		sub_d   = sub_q;
		done_d  = done_q;
		fb_d    = fb_q;
		voice   = 1'b0;
		comp    = 1'b0;
		case (kind)
			KIND_TICK: begin
				if (run_q == RUN_ACTIVE) begin
					phase_d = adv_phase;
					run_d   = adv_run;
					cnt_d   = adv_cnt;
					stamp_d = now_ms;
					sub_d   = adv_sub;
					done_d  = adv_done;
				end
			end
			KIND_PREV_PAGE: begin
				page_d = (page_q == PAGE_OVERVIEW) ? PAGE_FOCUS : page_q - 2'd1;
				fb_d   = page_feedback(page_d);
			end
			KIND_NEXT_PAGE: begin
				page_d = (page_q >= PAGE_FOCUS) ? PAGE_OVERVIEW : page_q + 2'd1;
				fb_d   = page_feedback(page_d);
			end
			KIND_CENTER_SHORT: begin
				page_d = PAGE_FOCUS;
				if (run_q == RUN_ACTIVE) begin
					phase_d = adv_phase;
					cnt_d   = adv_cnt;
					stamp_d = now_ms;
					sub_d   = adv_sub;
					done_d  = adv_done;
					if (adv_run == RUN_ACTIVE) begin
						run_d = RUN_PAUSED;
						fb_d  = FB_PAUSED;
					end else begin
						run_d = adv_run;
					end
				end else begin
					fb_d    = (run_q == RUN_PAUSED) ? FB_RESUMED : FB_STARTED;
					run_d   = RUN_ACTIVE;
					stamp_d = now_ms;
				end
			end
			KIND_CENTER_LONG: begin
				if (page_q != PAGE_FOCUS) begin
					fb_d  = FB_VOICE_OFF;
					voice = 1'b1;
				end else begin
					phase_d = PHASE_FOCUS;
					run_d   = RUN_READY;
					cnt_d   = reload(focus_len);
					sub_d   = '0;
					done_d  = 1'b0;
					fb_d    = FB_RESET;
				end
			end
			KIND_CONSUME: begin
				comp   = done_q;
				done_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.page         = page_d;
		res.phase        = phase_d;
		res.run_state    = run_d;
		res.seconds_left = 16'(cnt_d);
		res.feedback     = fb_d;
		res.voice_off    = voice;
		res.completed    = comp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= PAGE_OVERVIEW;
			phase_q <= PHASE_FOCUS;
			run_q   <= RUN_READY;
			cnt_q   <= reload(FOCUS_RESET);
			stamp_q <= '0;
			sub_q   <= '0;
			done_q  <= 1'b0;
			fb_q    <= FB_NONE;
		end else if (upd) begin
			page_q  <= page_d;
			phase_q <= phase_d;
			run_q   <= run_d;
			cnt_q   <= cnt_d;
			stamp_q <= stamp_d;
			sub_q   <= sub_d;
			done_q  <= done_d;
			fb_q    <= fb_d;
		end
	end

	`FBIT_ASSERT_SAME(a_sub_below_second, clk, arst_n, 1'b1, sub_q < MS_PER_SECOND)
	`FBIT_ASSERT_NEXT(a_consume_clears, clk, arst_n, upd && kind == KIND_CONSUME, !done_q)
	`FBIT_ASSERT_NEXT(a_short_to_focus, clk, arst_n, upd && kind == KIND_CENTER_SHORT,
		page_q == PAGE_FOCUS)
	`FBIT_ASSERT_NEXT(a_long_resets, clk, arst_n,
		upd && kind == KIND_CENTER_LONG && page_q == PAGE_FOCUS,
		run_q == RUN_READY && phase_q == PHASE_FOCUS && sub_q == '0)
	`FBIT_ASSERT_NEXT(a_expire_ready, clk, arst_n,
		upd && kind == KIND_TICK && run_q == RUN_ACTIVE && adv_run == RUN_READY, done_q)

endmodule

FILE: rtl/focus_break_interval_timer_unit.sv
// Channel   | Dir | Fields (tdata/tuser, lowest bit first)
// s_        | in  | tuser: kind[2:0]; tdata: now_ms[31:0]
// m_        | out | tdata: page[1:0] phase[2] run_state[4:3] seconds_left[20:5]
//           |     |        feedback[24:21] voice_off[25] completed[26] zero[31:27]
// cfg_      | in  | index 0 focus_length_seconds, 1 break_length_seconds
//
// One item per cycle while m_tready is high; each item crosses the input and result registers.
// The timer state updates as an item moves from the input register to the result
// register; the divide by 1000 and the countdown update are combinational between them.
// A held result stalls the input register only; the input side stays open while
// the input register is empty.
// arst_n clears all control state; lengths reset to 1500 and 300 seconds.
module focus_break_interval_timer_unit
	import fbit_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [STAMP_W-1:0]    s_tdata,   // now_ms
	input  logic [2:0]            s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // page, phase, run_state, seconds_left,
	                                         // feedback, voice_off, completed
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LEN_W-1:0]      cfg_wdata
);

	logic                  v_s1;
	logic [2:0]            kind_s1;
	logic [STAMP_W-1:0]    now_s1;
	logic                  out_valid_q;
	fbit_res_t             out_res_q;
	fbit_res_t             res;
	logic [LEN_W-1:0]      focus_len_q;
	logic [LEN_W-1:0]      break_len_q;
	logic                  fire;

	assign fire     = v_s1 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_len_q <= FOCUS_RESET;
			break_len_q <= BREAK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCUS_LEN: focus_len_q <= cfg_wdata;
				REG_BREAK_LEN: break_len_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			now_s1  <= s_tdata;
		end
	end

	fbit_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (fire),
		.kind      (kind_s1),
		.now_ms    (now_s1),
		.focus_len (focus_len_q),
		.break_len (break_len_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_res_q);

endmodule
